### sv/c8tfd_pkg.sv
// ----------------------------------------------------------------------------
// c8tfd_pkg: shared types and constants of the CRC-8 text frame deframer
// Phase and status codes, the frame job record passed from the parser to the
// output drain, and the reflected CRC-8 byte update.
// ----------------------------------------------------------------------------
package c8tfd_pkg;

  // Payload count width; holds counts up to 127, enough for the default payload buffer of 64.
  localparam int CNT_W = 7;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CFG_START_HEADER = 2'd0,
    CFG_START_TEXT   = 2'd1,
    CFG_END_TEXT     = 2'd2,
    CFG_END_FRAME    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HEAD  = 3'd1,
    PH_TEXT  = 3'd2,
    PH_FOOT0 = 3'd3,
    PH_FOOT  = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SG_LEAD = 2'd0,
    SG_POS  = 2'd1,
    SG_NEG  = 2'd2,
    SG_DONE = 2'd3
  } sign_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_NO_TEXT    = 3'd3,
    ST_LEN        = 3'd4,
    ST_CRC        = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_ADDR = 2'd1,
    B_DATA = 2'd2,
    B_SHOW = 2'd3
  } bstate_t;

  // One closed frame: which buffer bank, how many payload bytes, verdict.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    status_t          status;
  } job_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // Keep the lower-numbered error.
  function automatic status_t note_err(input status_t pend, input status_t code);
    if (pend == ST_OK || code < pend) begin
      return code;
    end
    return pend;
  endfunction

endpackage

### sv/c8tfd_ram.sv
// ----------------------------------------------------------------------------
// c8tfd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module c8tfd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/c8tfd_front.sv
// ----------------------------------------------------------------------------
// c8tfd_front: frame parser
// Holds the code registers, tracks the frame phase, parses header and footer
// text, runs the CRC, writes payload bytes to the current buffer bank and
// issues one job per closed frame.
// ----------------------------------------------------------------------------
module c8tfd_front import c8tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 64,
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [7:0]     cfg_wdata,
  input  logic           acc,
  input  logic [7:0]     rx_byte,
  output logic           ram_we,
  output logic [IDX_W:0] ram_waddr,
  output logic [7:0]     ram_wdata,
  output logic           job_push,
  output job_t           job
);

  logic [7:0] soh_r, stx_r, etx_r, eof_r;

  phase_t           phase_r, phase_nxt;
  logic             first_ok_r, first_ok_nxt;
  logic [15:0]      hdr_r, hdr_nxt;
  sign_t            sign_r, sign_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       fv_r, fv_nxt;
  logic             fok_r, fok_nxt;
  status_t          perr_r, perr_nxt;
  logic             bank_r, bank_nxt;

  logic        is_eof, is_stx, is_etx, is_dig, is_ws, has_room;
  logic [19:0] hmul;
  logic [11:0] fmul;
  status_t     verdict;

  assign is_eof   = (rx_byte == eof_r);
  assign is_stx   = (rx_byte == stx_r);
  assign is_etx   = (rx_byte == etx_r);
  assign is_dig   = (rx_byte inside {[CH_ZERO:CH_NINE]});
  assign is_ws    = (rx_byte inside {[CH_TAB:CH_CR], CH_SPACE});
  assign has_room = (cnt_r < CNT_W'(MAX_PAYLOAD));
  assign hmul = ({4'd0, hdr_r} << 3) + ({4'd0, hdr_r} << 1) + 20'(rx_byte[3:0]);
  assign fmul = ({4'd0, fv_r} << 3) + ({4'd0, fv_r} << 1) + 12'(rx_byte[3:0]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soh_r <= 8'h01;
      stx_r <= 8'h02;
      etx_r <= 8'h03;
      eof_r <= 8'h04;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_HEADER: soh_r <= cfg_wdata;
        CFG_START_TEXT:   stx_r <= cfg_wdata;
        CFG_END_TEXT:     etx_r <= cfg_wdata;
        CFG_END_FRAME:    eof_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame verdict from the state left before the end-of-frame byte
  always_comb begin
    if (phase_r == PH_IDLE) begin
      verdict = (soh_r == 8'h00) ? ST_BAD_HEADER : ST_BAD_START;
    end else if (!first_ok_r) begin
      verdict = ST_BAD_START;
    end else if (phase_r == PH_HEAD) begin
      verdict = ST_BAD_HEADER;
    end else if (perr_r != ST_OK) begin
      verdict = perr_r;
    end else if (phase_r != PH_FOOT0 && phase_r != PH_FOOT) begin
      verdict = ST_NO_TEXT;
    end else if (hdr_r != 16'(cnt_r)) begin
      verdict = ST_LEN;
    end else if (phase_r != PH_FOOT || !fok_r || fv_r != crc_r) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end
  end

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    first_ok_nxt = first_ok_r;
    hdr_nxt      = hdr_r;
    sign_nxt     = sign_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    fv_nxt       = fv_r;
    fok_nxt      = fok_r;
    perr_nxt     = perr_r;
    bank_nxt     = bank_r;
    if (acc) begin
      if (is_eof) begin
        // close the frame and swap banks
        phase_nxt    = PH_IDLE;
        first_ok_nxt = 1'b0;
        hdr_nxt      = '0;
        sign_nxt     = SG_LEAD;
        cnt_nxt      = '0;
        crc_nxt      = '0;
        fv_nxt       = '0;
        fok_nxt      = 1'b0;
        perr_nxt     = ST_OK;
        bank_nxt     = ~bank_r;
      end else begin
        case (phase_r)
          PH_IDLE, PH_HEAD: begin
            if (phase_r == PH_IDLE) begin
              first_ok_nxt = (rx_byte == soh_r);
            end
            if (is_stx) begin
              if (sign_r == SG_NEG && hdr_r != 16'd0) begin
                perr_nxt = note_err(perr_nxt, ST_BAD_HEADER);
              end
              if (is_etx) begin
                perr_nxt  = note_err(perr_nxt, ST_NO_TEXT);
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_TEXT;
              end
            end else begin
              if (is_etx) begin
                perr_nxt = note_err(perr_nxt, ST_NO_TEXT);
              end
              if (phase_r == PH_IDLE) begin
                phase_nxt = PH_HEAD;
              end else begin
                case (sign_r)
                  SG_LEAD: begin
                    if (is_ws) begin
                      sign_nxt = SG_LEAD;
                    end else if (rx_byte == CH_PLUS) begin
                      sign_nxt = SG_POS;
                    end else if (rx_byte == CH_MINUS) begin
                      sign_nxt = SG_NEG;
                    end else if (is_dig) begin
                      hdr_nxt  = 16'(rx_byte[3:0]);
                      sign_nxt = SG_POS;
                    end else begin
                      sign_nxt = SG_DONE;
                    end
                  end
                  SG_POS, SG_NEG: begin
                    if (is_dig) begin
                      hdr_nxt = (hmul[19:16] != 4'd0) ? 16'hFFFF : hmul[15:0];
                    end else begin
                      if (sign_r == SG_NEG && hdr_r != 16'd0) begin
                        perr_nxt = note_err(perr_nxt, ST_BAD_HEADER);
                      end
                      sign_nxt = SG_DONE;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
          PH_TEXT: begin
            if (is_etx) begin
              if (cnt_r == '0) begin
                perr_nxt  = note_err(perr_nxt, ST_NO_TEXT);
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_FOOT0;
              end
            end else begin
              crc_nxt = crc8_step(crc_r, rx_byte);
              if (has_room) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                perr_nxt = note_err(perr_nxt, ST_OVERFLOW);
              end
            end
          end
          PH_FOOT0: begin
            if (is_dig) begin
              fv_nxt  = 8'(rx_byte[3:0]);
              fok_nxt = 1'b1;
            end else begin
              fok_nxt = 1'b0;
            end
            phase_nxt = PH_FOOT;
          end
          PH_FOOT: begin
            if (fok_r) begin
              if (is_dig && fv_r != 8'd0) begin
                if (fmul <= 12'd255) begin
                  fv_nxt = fmul[7:0];
                end else begin
                  fok_nxt = 1'b0;
                end
              end else begin
                fok_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    ram_we       = acc && !is_eof && phase_r == PH_TEXT && !is_etx && has_room;
    ram_waddr    = {bank_r, cnt_r[IDX_W-1:0]};
    ram_wdata    = rx_byte;
    job_push     = acc && is_eof;
    job.bank     = bank_r;
    job.count    = cnt_r;
    job.status   = verdict;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      first_ok_r <= 1'b0;
      hdr_r      <= '0;
      sign_r     <= SG_LEAD;
      cnt_r      <= '0;
      crc_r      <= '0;
      fv_r       <= '0;
      fok_r      <= 1'b0;
      perr_r     <= ST_OK;
      bank_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      first_ok_r <= first_ok_nxt;
      hdr_r      <= hdr_nxt;
      sign_r     <= sign_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      fv_r       <= fv_nxt;
      fok_r      <= fok_nxt;
      perr_r     <= perr_nxt;
      bank_r     <= bank_nxt;
    end
  end

endmodule

### sv/c8tfd_jobq.sv
// ----------------------------------------------------------------------------
// c8tfd_jobq: two-entry job queue
// Holds closed frames until the drain has delivered their last item. An entry
// leaves only when its drain finishes, so a full queue means both payload
// banks are taken.
// ----------------------------------------------------------------------------
module c8tfd_jobq import c8tfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nempty,
  output job_t head
);

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign nempty = (cnt_r != 2'd0);
  assign head   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nempty)
    else $error("job popped from an empty queue");

endmodule

### sv/c8tfd_back.sv
// ----------------------------------------------------------------------------
// c8tfd_back: output drain
// Takes the head job, emits one error item or walks the payload bank through
// the RAM read port, and holds each item in the output register until taken.
// ----------------------------------------------------------------------------
module c8tfd_back import c8tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 64,
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nempty,
  input  job_t           q_head,
  output logic           q_pop,
  output logic [IDX_W:0] ram_raddr,
  input  logic [7:0]     ram_rdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_data,
  output logic           out_last,
  output status_t        out_status
);

  bstate_t          st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  status_t          stat_r, stat_nxt;

  // Next state
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    data_nxt = data_r;
    last_nxt = last_r;
    stat_nxt = stat_r;
    case (st_r)
      B_IDLE: begin
        if (q_nempty) begin
          if (q_head.status != ST_OK) begin
            data_nxt = 8'h00;
            last_nxt = 1'b1;
            stat_nxt = q_head.status;
            st_nxt   = B_SHOW;
          end else begin
            idx_nxt = '0;
            st_nxt  = B_ADDR;
          end
        end
      end
      B_ADDR: st_nxt = B_DATA;
      B_DATA: begin
        data_nxt = ram_rdata;
        last_nxt = (idx_r == q_head.count - CNT_W'(1));
        stat_nxt = ST_OK;
        st_nxt   = B_SHOW;
      end
      B_SHOW: begin
        if (out_tready) begin
          if (last_r) begin
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            st_nxt  = B_ADDR;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    out_tvalid = (st_r == B_SHOW);
    out_data   = data_r;
    out_last   = last_r;
    out_status = stat_r;
    q_pop      = (st_r == B_SHOW) && out_tready && last_r;
    ram_raddr  = {q_head.bank, idx_r[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    idx_r  <= idx_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    stat_r <= stat_nxt;
  end

  a_busy_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != B_IDLE) |-> q_nempty)
    else $error("drain active without a job");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status != ST_OK) |-> (out_last && out_data == 8'h00))
    else $error("error item not marked last or carries data");

endmodule

### sv/crc8_text_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// crc8_text_frame_deframer_unit: receive-side text frame deframer
// Parses SOH / length text / STX / payload / ETX / CRC-8 text / EOT frames
// and delivers the payload of good frames or one error item per bad frame.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock while fewer than two closed
// frames are waiting; it stalls only when both payload banks are held by
// frames not yet fully delivered. Payload lives in a RAM of two banks of
// 2**ceil(log2(MAX_PAYLOAD)) bytes each, so one frame drains while the next
// one fills. The drain reads that RAM through one registered read port:
// a payload byte passes the address, read-data and output-register states
// and waits for out_tready, with an idle state to pick up each frame; an
// error item skips the RAM. Configuration writes take effect on the
// next clock and are meant to be made while the unit is idle.
module crc8_text_frame_deframer_unit import c8tfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // input bytes
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  // result items
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast,  // last_of_run
  output logic [2:0] out_tuser,  // [2:0] frame_status
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RAM_DEPTH = 2 * (1 << IDX_W);

  logic           acc;
  logic           ram_we;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           job_push, q_pop, q_full, q_nempty;
  job_t           job, q_head;
  status_t        out_status;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign out_tuser = out_status;

  c8tfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job)
  );

  c8tfd_ram #(.DATA_W(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  c8tfd_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  c8tfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (q_nempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_status)
  );

endmodule
